// ===== hdl/bals_pkg.sv =====
package bals_pkg;

  // Configuration port geometry: four 32-bit registers at byte addresses 0, 4, 8 and 12.
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef logic [9:0] timer_t;

  // Timers count up to 999 and then stick at 1000.
  localparam timer_t TIMER_SAT_EDGE = 10'd999;
  localparam timer_t TIMER_SAT_TOP  = 10'd1000;
  localparam timer_t LIMIT_RESET    = 10'd100;

  typedef enum logic [1:0] {
    REG_ALT_RELEASE = 2'd0,
    REG_ALT_WAIT    = 2'd1,
    REG_AC_INHIBIT  = 2'd2,
    REG_AC_WAIT     = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_OFF           = 6'b000001,
    ST_ALT           = 6'b000010,
    ST_AC            = 6'b000100,
    ST_BOTH          = 6'b001000,
    ST_AC_AFTER_ALT  = 6'b010000,
    ST_ALT_AFTER_AC  = 6'b100000
  } mode_st_t;

  typedef logic [2:0] mode_code_t;

  localparam mode_code_t MODE_OFF          = 3'd0;
  localparam mode_code_t MODE_ALT          = 3'd1;
  localparam mode_code_t MODE_AC           = 3'd2;
  localparam mode_code_t MODE_BOTH         = 3'd3;
  localparam mode_code_t MODE_AC_AFTER_ALT = 3'd4;
  localparam mode_code_t MODE_ALT_AFTER_AC = 3'd5;

  typedef struct packed {
    timer_t alt_release;
    timer_t alt_wait;
    timer_t ac_inhibit;
    timer_t ac_wait;
  } limits_t;

  typedef struct packed {
    mode_code_t mode;
    logic       release_alternator;
    logic       inhibit_ac;
  } result_t;

  function automatic timer_t sat_inc(input timer_t t);
    return (t < TIMER_SAT_EDGE) ? t + 10'd1 : TIMER_SAT_TOP;
  endfunction

  function automatic mode_code_t mode_code(input mode_st_t s);
    mode_code_t m;
    case (s)
      ST_OFF:          m = MODE_OFF;
      ST_ALT:          m = MODE_ALT;
      ST_AC:           m = MODE_AC;
      ST_BOTH:         m = MODE_BOTH;
      ST_AC_AFTER_ALT: m = MODE_AC_AFTER_ALT;
      ST_ALT_AFTER_AC: m = MODE_ALT_AFTER_AC;
      default:         m = MODE_OFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/bals_cfg.sv =====
module bals_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bals_pkg::AddrW-1:0] paddr,
  input  logic [bals_pkg::DataW-1:0] pwdata,
  output logic [bals_pkg::DataW-1:0] prdata,
  output bals_pkg::limits_t          limits
);

  bals_pkg::limits_t  lim_r;
  bals_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = bals_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.alt_release <= bals_pkg::LIMIT_RESET;
      lim_r.alt_wait    <= bals_pkg::LIMIT_RESET;
      lim_r.ac_inhibit  <= bals_pkg::LIMIT_RESET;
      lim_r.ac_wait     <= bals_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        bals_pkg::REG_ALT_RELEASE: lim_r.alt_release <= pwdata[9:0];
        bals_pkg::REG_ALT_WAIT:    lim_r.alt_wait    <= pwdata[9:0];
        bals_pkg::REG_AC_INHIBIT:  lim_r.ac_inhibit  <= pwdata[9:0];
        bals_pkg::REG_AC_WAIT:     lim_r.ac_wait     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bals_pkg::REG_ALT_RELEASE: prdata = {22'd0, lim_r.alt_release};
      bals_pkg::REG_ALT_WAIT:    prdata = {22'd0, lim_r.alt_wait};
      bals_pkg::REG_AC_INHIBIT:  prdata = {22'd0, lim_r.ac_inhibit};
      bals_pkg::REG_AC_WAIT:     prdata = {22'd0, lim_r.ac_wait};
      default:                   prdata = '0;
    endcase
  end

  assign limits = lim_r;

endmodule

// ===== hdl/bals_core.sv =====
module bals_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                assist_active,
  input  logic                alt_condition,
  input  logic                immediate_strategy,
  input  logic                ac_condition,
  input  bals_pkg::limits_t   limits,
  output bals_pkg::result_t   result
);

  bals_pkg::mode_st_t st_r, st_nxt;
  logic               rel_r, rel_nxt;
  logic               inh_r, inh_nxt;
  bals_pkg::timer_t   alt_rel_r, alt_rel_nxt;
  bals_pkg::timer_t   alt_wait_r, alt_wait_nxt;
  bals_pkg::timer_t   ac_inh_r, ac_inh_nxt;
  bals_pkg::timer_t   ac_wait_r, ac_wait_nxt;
  logic               alt_end;
  logic               ac_end;
  logic               go_off;

  assign alt_end = alt_rel_r >= limits.alt_release;
  assign ac_end  = ac_inh_r >= limits.ac_inhibit;

  always_comb begin
    st_nxt       = st_r;
    rel_nxt      = rel_r;
    inh_nxt      = inh_r;
    alt_rel_nxt  = alt_rel_r;
    alt_wait_nxt = alt_wait_r;
    ac_inh_nxt   = ac_inh_r;
    ac_wait_nxt  = ac_wait_r;
    go_off       = 1'b0;

    case (st_r)
      bals_pkg::ST_OFF: begin
        if (assist_active) begin
          if (!alt_condition && !immediate_strategy) begin
            st_nxt  = bals_pkg::ST_ALT;
            rel_nxt = 1'b1;
            inh_nxt = 1'b0;
          end else if (immediate_strategy || ac_condition) begin
            st_nxt  = bals_pkg::ST_BOTH;
            rel_nxt = 1'b1;
            inh_nxt = 1'b1;
          end else begin
            st_nxt  = bals_pkg::ST_AC;
            rel_nxt = 1'b0;
            inh_nxt = 1'b1;
          end
        end
      end
      bals_pkg::ST_ALT: begin
        if (!assist_active || alt_end) begin
          go_off = 1'b1;
        end else if (alt_wait_r >= limits.alt_wait) begin
          st_nxt  = bals_pkg::ST_BOTH;
          rel_nxt = 1'b1;
          inh_nxt = 1'b1;
        end else begin
          alt_rel_nxt  = bals_pkg::sat_inc(alt_rel_r);
          alt_wait_nxt = bals_pkg::sat_inc(alt_wait_r);
        end
      end
      bals_pkg::ST_AC: begin
        if (!assist_active || ac_end) begin
          go_off = 1'b1;
        end else if (ac_wait_r >= limits.ac_wait) begin
          st_nxt  = bals_pkg::ST_BOTH;
          rel_nxt = 1'b1;
          inh_nxt = 1'b1;
        end else begin
          ac_inh_nxt  = bals_pkg::sat_inc(ac_inh_r);
          ac_wait_nxt = bals_pkg::sat_inc(ac_wait_r);
        end
      end
      bals_pkg::ST_BOTH: begin
        if (!assist_active) begin
          go_off = 1'b1;
        end else if (alt_end) begin
          if (ac_end) begin
            go_off = 1'b1;
          end else begin
            st_nxt  = bals_pkg::ST_AC_AFTER_ALT;
            rel_nxt = 1'b0;
            inh_nxt = 1'b1;
          end
        end else if (ac_end) begin
          st_nxt  = bals_pkg::ST_ALT_AFTER_AC;
          rel_nxt = 1'b1;
          inh_nxt = 1'b0;
        end else begin
          alt_rel_nxt = bals_pkg::sat_inc(alt_rel_r);
          ac_inh_nxt  = bals_pkg::sat_inc(ac_inh_r);
        end
      end
      bals_pkg::ST_AC_AFTER_ALT: begin
        if (ac_end || !assist_active) begin
          go_off = 1'b1;
        end else begin
          ac_inh_nxt = bals_pkg::sat_inc(ac_inh_r);
        end
      end
      bals_pkg::ST_ALT_AFTER_AC: begin
        if (!assist_active || alt_end) begin
          go_off = 1'b1;
        end else begin
          alt_rel_nxt = bals_pkg::sat_inc(alt_rel_r);
        end
      end
      default: ;
    endcase

    // Any exit to off drops both actions and restarts every timer.
    if (go_off) begin
      st_nxt       = bals_pkg::ST_OFF;
      rel_nxt      = 1'b0;
      inh_nxt      = 1'b0;
      alt_rel_nxt  = '0;
      alt_wait_nxt = '0;
      ac_inh_nxt   = '0;
      ac_wait_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= bals_pkg::ST_OFF;
      rel_r      <= 1'b0;
      inh_r      <= 1'b0;
      alt_rel_r  <= '0;
      alt_wait_r <= '0;
      ac_inh_r   <= '0;
      ac_wait_r  <= '0;
    end else if (step) begin
      st_r       <= st_nxt;
      rel_r      <= rel_nxt;
      inh_r      <= inh_nxt;
      alt_rel_r  <= alt_rel_nxt;
      alt_wait_r <= alt_wait_nxt;
      ac_inh_r   <= ac_inh_nxt;
      ac_wait_r  <= ac_wait_nxt;
    end
  end

  assign result.mode               = bals_pkg::mode_code(st_nxt);
  assign result.release_alternator = rel_nxt;
  assign result.inhibit_ac         = inh_nxt;

endmodule

// ===== hdl/brake_assist_load_shed_supervisor_top.sv =====
// Brake-assist load-shed supervisor.
//
// Each transfer on the input channel (in_valid/in_ready) is one task tick carrying the
// assist request and three condition flags. For every tick exactly one result transfer
// follows on the output channel (out_valid/out_ready): the supervisor mode after the
// update and the alternator-release and AC-inhibit commands.
//
// A tick is held in an input register; once the output register is empty or being
// emptied, the supervisor step is evaluated from that register and the stored mode,
// flags and timers, and the result is captured in the output register. One tick per
// cycle is sustained while the receiver does not stall, the limit being the single
// state update of the supervisor per cycle.
//
// When the receiver stalls, the finished result waits in the output register while the
// input register can still take one more tick; in_ready drops only when both are full.
// A synchronous reset (rst_n low) empties both registers, returns the supervisor to off,
// clears all timers and loads the four limits with 100. The user must write the limits
// at APB byte addresses 0, 4, 8, 12 only while no tick is in flight; it is not enforced.
module brake_assist_load_shed_supervisor_top (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_assist_active,
  input  logic                       in_alt_condition,
  input  logic                       in_immediate_strategy,
  input  logic                       in_ac_condition,

  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_mode,
  output logic                       out_release_alternator,
  output logic                       out_inhibit_ac,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bals_pkg::AddrW-1:0] paddr,
  input  logic [bals_pkg::DataW-1:0] pwdata,
  output logic [bals_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  // Input register.
  logic in_vld_r;
  logic assist_r;
  logic altc_r;
  logic imm_r;
  logic acc_r;

  // Output register.
  logic              out_vld_r;
  bals_pkg::result_t out_res_r;

  bals_pkg::limits_t limits;
  bals_pkg::result_t step_res;
  logic              advance;
  logic              in_xfer;

  // The held tick moves on whenever the output register is empty or being emptied.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  assign pready = 1'b1;

  bals_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .limits  (limits)
  );

  bals_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (advance),
    .assist_active      (assist_r),
    .alt_condition      (altc_r),
    .immediate_strategy (imm_r),
    .ac_condition       (acc_r),
    .limits             (limits),
    .result             (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      assist_r <= in_assist_active;
      altc_r   <= in_alt_condition;
      imm_r    <= in_immediate_strategy;
      acc_r    <= in_ac_condition;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_mode               = out_res_r.mode;
  assign out_release_alternator = out_res_r.release_alternator;
  assign out_inhibit_ac         = out_res_r.inhibit_ac;

`ifndef NO_ASSERTIONS
  // A new tick is only taken when the held one is leaving or the input register is empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!in_vld_r || advance))
    else $error("tick taken while the input register was blocked");

  // Every step of the supervisor produces a result in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("supervisor step produced no result");

  // The release command follows the mode: on in alt, both and alt-after-AC only.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.release_alternator ==
                   (out_res_r.mode == bals_pkg::MODE_ALT ||
                    out_res_r.mode == bals_pkg::MODE_BOTH ||
                    out_res_r.mode == bals_pkg::MODE_ALT_AFTER_AC)))
    else $error("release command disagrees with mode");

  // The inhibit command follows the mode: on in AC, both and AC-after-alt only.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.inhibit_ac ==
                   (out_res_r.mode == bals_pkg::MODE_AC ||
                    out_res_r.mode == bals_pkg::MODE_BOTH ||
                    out_res_r.mode == bals_pkg::MODE_AC_AFTER_ALT)))
    else $error("inhibit command disagrees with mode");

  // A stalled result is neither lost nor overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(out_res_r)))
    else $error("stalled result changed");
`endif

endmodule

// ===== dv/brake_assist_load_shed_supervisor_top_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the brake-assist load-shed supervisor.
//
// Every transfer on the input channel is one task tick, and each tick produces
// exactly one result transfer. The bench keeps its own copy of the supervisor:
// mode, flags, the four saturating timers and the four limits. Each time a tick
// is accepted it steps that copy and queues the outcome. Results are then
// checked in order, field by field, against the head of the queue.
module brake_assist_load_shed_supervisor_top_tb;

  // A row of the directed table. Where has_exp is set, the row carries its own
  // expected outcome and that value is queued. Otherwise the shadow
  // supervisor's outcome is queued.
  typedef struct packed {
    logic                 assist;
    logic                 alt_c;
    logic                 imm;
    logic                 ac_c;
    logic                 has_exp;
    bals_pkg::mode_code_t mode;
    logic                 rel;
    logic                 inh;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic in_assist_active = 1'b0;
  logic in_alt_condition = 1'b0;
  logic in_immediate_strategy = 1'b0;
  logic in_ac_condition = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_mode;
  logic       out_release_alternator;
  logic       out_inhibit_ac;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [bals_pkg::AddrW-1:0] paddr = '0;
  logic [bals_pkg::DataW-1:0] pwdata = '0;
  logic [bals_pkg::DataW-1:0] prdata;
  logic                       pready;

  // Shadow copy of the supervisor and its calibration.
  bals_pkg::limits_t    shed_limits;
  bals_pkg::mode_code_t sup_mode;
  logic                 sup_release;
  logic                 sup_inhibit;
  bals_pkg::timer_t     alt_release_tmr;
  bals_pkg::timer_t     alt_wait_tmr;
  bals_pkg::timer_t     ac_inhibit_tmr;
  bals_pkg::timer_t     ac_wait_tmr;

  bals_pkg::result_t pending_results[$];
  bals_pkg::result_t head_result;
  int      fail_count = 0;
  // While this is set, neither side inserts idle cycles.
  bit      no_gaps = 1'b0;

  // Directed ticks, applied with the limits at their reset value of 100.
  tick_row_t directed_ticks [0:18] = '{
    // Straight after reset, without assist, the block stays off.
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    // No alternator condition and no immediate strategy: alternator release only.
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, bals_pkg::MODE_ALT, 1'b1, 1'b0},
    // Once in a mode, the condition flags no longer matter.
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, bals_pkg::MODE_ALT, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    // The AC condition on its own still leads to alternator release only.
    '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, bals_pkg::MODE_ALT, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    // An alternator condition without AC condition or strategy: AC inhibit only.
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, bals_pkg::MODE_AC, 1'b0, 1'b1},
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, bals_pkg::MODE_AC, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    // Alternator and AC conditions together: both actions.
    '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, bals_pkg::MODE_BOTH, 1'b1, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    // The immediate strategy asks for both actions.
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, bals_pkg::MODE_BOTH, 1'b1, 1'b1},
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, bals_pkg::MODE_BOTH, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, bals_pkg::MODE_BOTH, 1'b1, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, bals_pkg::MODE_OFF, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, bals_pkg::MODE_OFF, 1'b0, 1'b0}
  };

  brake_assist_load_shed_supervisor_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_assist_active       (in_assist_active),
    .in_alt_condition       (in_alt_condition),
    .in_immediate_strategy  (in_immediate_strategy),
    .in_ac_condition        (in_ac_condition),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_mode               (out_mode),
    .out_release_alternator (out_release_alternator),
    .out_inhibit_ac         (out_inhibit_ac),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #1 clk = ~clk;

  // A timer counts on up to 999 and then sticks at 1000.
  function automatic bals_pkg::timer_t bump_timer(input bals_pkg::timer_t t);
    return (t < bals_pkg::TIMER_SAT_EDGE) ? t + 10'd1 : bals_pkg::TIMER_SAT_TOP;
  endfunction

  task automatic enter_mode(input bals_pkg::mode_code_t m, input logic rel, input logic inh);
    sup_mode = m;
    sup_release = rel;
    sup_inhibit = inh;
  endtask

  // Any return to off clears the flags and all four timers.
  task automatic shut_off();
    enter_mode(bals_pkg::MODE_OFF, 1'b0, 1'b0);
    alt_release_tmr = '0;
    alt_wait_tmr = '0;
    ac_inhibit_tmr = '0;
    ac_wait_tmr = '0;
  endtask

  // Advances the shadow supervisor by one tick and returns the outcome.
  task automatic step_supervisor(input logic assist, input logic alt_c, input logic imm,
                                 input logic ac_c, output bals_pkg::result_t res);
    logic alt_end;
    logic ac_end;
    // The end conditions are taken from the timers as they stood before this tick.
    alt_end = alt_release_tmr >= shed_limits.alt_release;
    ac_end = ac_inhibit_tmr >= shed_limits.ac_inhibit;
    case (sup_mode)
      bals_pkg::MODE_OFF: begin
        if (assist) begin
          if (!alt_c && !imm) enter_mode(bals_pkg::MODE_ALT, 1'b1, 1'b0);
          else if (imm || ac_c) enter_mode(bals_pkg::MODE_BOTH, 1'b1, 1'b1);
          else enter_mode(bals_pkg::MODE_AC, 1'b0, 1'b1);
        end
      end
      bals_pkg::MODE_ALT: begin
        if (!assist || alt_end) begin
          shut_off();
        end else if (alt_wait_tmr >= shed_limits.alt_wait) begin
          enter_mode(bals_pkg::MODE_BOTH, 1'b1, 1'b1);
        end else begin
          alt_release_tmr = bump_timer(alt_release_tmr);
          alt_wait_tmr = bump_timer(alt_wait_tmr);
        end
      end
      bals_pkg::MODE_AC: begin
        if (!assist || ac_end) begin
          shut_off();
        end else if (ac_wait_tmr >= shed_limits.ac_wait) begin
          enter_mode(bals_pkg::MODE_BOTH, 1'b1, 1'b1);
        end else begin
          ac_inhibit_tmr = bump_timer(ac_inhibit_tmr);
          ac_wait_tmr = bump_timer(ac_wait_tmr);
        end
      end
      bals_pkg::MODE_BOTH: begin
        if (!assist || (alt_end && ac_end)) begin
          shut_off();
        end else if (alt_end) begin
          enter_mode(bals_pkg::MODE_AC_AFTER_ALT, 1'b0, 1'b1);
        end else if (ac_end) begin
          enter_mode(bals_pkg::MODE_ALT_AFTER_AC, 1'b1, 1'b0);
        end else begin
          alt_release_tmr = bump_timer(alt_release_tmr);
          ac_inhibit_tmr = bump_timer(ac_inhibit_tmr);
        end
      end
      bals_pkg::MODE_AC_AFTER_ALT: begin
        if (!assist || ac_end) shut_off();
        else ac_inhibit_tmr = bump_timer(ac_inhibit_tmr);
      end
      bals_pkg::MODE_ALT_AFTER_AC: begin
        if (!assist || alt_end) shut_off();
        else alt_release_tmr = bump_timer(alt_release_tmr);
      end
      default: begin
      end
    endcase
    res.mode = sup_mode;
    res.release_alternator = sup_release;
    res.inhibit_ac = sup_inhibit;
  endtask

  // Offers one tick, holds it until the transfer and queues what it should produce.
  // A row's own expectation, if it has one, takes the place of the shadow's.
  task automatic send_tick(input logic assist, input logic alt_c, input logic imm,
                           input logic ac_c, input logic has_exp,
                           input bals_pkg::result_t row_res);
    bals_pkg::result_t predicted;
    while (!no_gaps && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_assist_active <= assist;
    in_alt_condition <= alt_c;
    in_immediate_strategy <= imm;
    in_ac_condition <= ac_c;
    do @(posedge clk); while (!in_ready);
    step_supervisor(assist, alt_c, imm, ac_c, predicted);
    pending_results.push_back(has_exp ? row_res : predicted);
  endtask

  task automatic send_random_tick(input logic assist);
    send_tick(assist, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // Runs of held assist with random condition flags, separated by short breaks
  // without assist, so that the timers get a chance to reach their limits.
  // drop_pct adds the odd lost assist within a run.
  task automatic run_episodes(input int n_items, input int max_run, input int first_run,
                              input int drop_pct);
    int sent;
    int run_len;
    int k;
    sent = 0;
    run_len = first_run;
    while (sent < n_items) begin
      for (k = 0; k < run_len && sent < n_items; k++) begin
        send_random_tick($urandom_range(99) >= drop_pct);
        sent++;
      end
      for (k = $urandom_range(1, 3); k > 0 && sent < n_items; k--) begin
        send_random_tick(1'b0);
        sent++;
      end
      run_len = $urandom_range(1, max_run);
    end
  endtask

  // Stops offering ticks and waits until every queued result has been delivered,
  // which leaves the block idle since every tick produces one result.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One APB write: a setup cycle, then the access cycle, which ends on pready.
  // Only the low ten bits belong to a limit, so the upper bits are noise.
  task automatic write_limit(input bals_pkg::reg_idx_t idx, input bals_pkg::timer_t val);
    logic [bals_pkg::DataW-1:0] word;
    word = $urandom;
    word[9:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bals_pkg::REG_ALT_RELEASE: shed_limits.alt_release = val;
      bals_pkg::REG_ALT_WAIT:    shed_limits.alt_wait = val;
      bals_pkg::REG_AC_INHIBIT:  shed_limits.ac_inhibit = val;
      bals_pkg::REG_AC_WAIT:     shed_limits.ac_wait = val;
      default: begin
      end
    endcase
  endtask

  task automatic write_all_limits(input bals_pkg::timer_t alt_rel,
                                  input bals_pkg::timer_t alt_wt,
                                  input bals_pkg::timer_t ac_inh,
                                  input bals_pkg::timer_t ac_wt);
    write_limit(bals_pkg::REG_ALT_RELEASE, alt_rel);
    write_limit(bals_pkg::REG_ALT_WAIT, alt_wt);
    write_limit(bals_pkg::REG_AC_INHIBIT, ac_inh);
    write_limit(bals_pkg::REG_AC_WAIT, ac_wt);
  endtask

  // Result side: checks each result transfer against the oldest queued outcome.
  // out_ready is stalled about one cycle in nine, except in the stretch without gaps.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: mode %0d release %0b inhibit %0b",
                 $time, out_mode, out_release_alternator, out_inhibit_ac);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_mode !== head_result.mode) begin
          $display("%0t: mode expected %0d, actual %0d",
                   $time, head_result.mode, out_mode);
          fail_count++;
        end
        if (out_release_alternator !== head_result.release_alternator) begin
          $display("%0t: release_alternator expected %0b, actual %0b",
                   $time, head_result.release_alternator, out_release_alternator);
          fail_count++;
        end
        if (out_inhibit_ac !== head_result.inhibit_ac) begin
          $display("%0t: inhibit_ac expected %0b, actual %0b",
                   $time, head_result.inhibit_ac, out_inhibit_ac);
          fail_count++;
        end
      end
    end
    out_ready <= no_gaps || ($urandom_range(99) >= 11);
  end

  initial begin
    int i;
    shed_limits = '{bals_pkg::LIMIT_RESET, bals_pkg::LIMIT_RESET,
                    bals_pkg::LIMIT_RESET, bals_pkg::LIMIT_RESET};
    shut_off();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks, walked in order.
    for (i = 0; i < $size(directed_ticks); i++) begin
      send_tick(directed_ticks[i].assist, directed_ticks[i].alt_c, directed_ticks[i].imm,
                directed_ticks[i].ac_c, directed_ticks[i].has_exp,
                '{directed_ticks[i].mode, directed_ticks[i].rel, directed_ticks[i].inh});
    end

    // Reset limits: the first run is long enough to reach the limit of 100.
    run_episodes(120, 130, 105, 3);
    drain();

    // All limits zero: every limit counts as reached at once.
    write_all_limits(10'd0, 10'd0, 10'd0, 10'd0);
    run_episodes(50, 6, 3, 5);
    drain();

    // Small random limits, first with both sides at full rate throughout.
    no_gaps = 1'b1;
    write_all_limits(10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)),
                     10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)));
    run_episodes(75, 40, 20, 3);
    drain();
    no_gaps = 1'b0;
    write_all_limits(10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)),
                     10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)));
    run_episodes(75, 40, 20, 3);
    drain();

    // Top of the range: one unbroken assist run long enough for the timers to
    // saturate. A limit of 1023 lies above 1000 and so is never reached.
    write_all_limits(10'd1023, 10'd1000, 10'd1000, 10'd0);
    run_episodes(1030, 40, 1010, 0);
    drain();

    // Allow a few more cycles for any stray result to show up.
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #100000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== brake_assist_load_shed_supervisor_top.f =====
hdl/bals_pkg.sv
hdl/bals_cfg.sv
hdl/bals_core.sv
hdl/brake_assist_load_shed_supervisor_top.sv
dv/brake_assist_load_shed_supervisor_top_tb.sv
